// ----- rtl/bss_pkg.sv -----
package bss_pkg;

    // Store sizes and derived widths
    localparam int MAX_STRINGS = 64;
    localparam int MAX_BYTES   = 1024;
    localparam int SIDX_W      = $clog2(MAX_STRINGS);
    localparam int SCNT_W      = SIDX_W + 1;
    localparam int BIDX_W      = $clog2(MAX_BYTES);
    localparam int BCNT_W      = BIDX_W + 1;
    localparam int OFS_W       = 11;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_byte;
        logic       in_byte_present;
        logic       in_string_end;
        logic       in_set_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_byte_present;
        logic             out_string_end;
        logic [OFS_W-1:0] offset_end;
        logic             last;
        t_status          status;
    } t_out_item;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;         // load transaction in loading phase
        logic err_out;      // drain while loading: empty-status result
        logic i_init;       // outer sort index to 1
        logic ord_rd_i;     // read order[i]
        logic ord_rd_jm1;   // read order[j-1]
        logic ord_rd_rank;  // read order[rank]
        logic key_cap;      // capture key, j = i, read its table entry
        logic key_len_cap;  // capture key start/length
        logic oth_cap;      // capture other, read its table entry
        logic oth_len_cap;  // capture other start/length, k = 0
        logic cmp_rd;       // read both strings at offset k
        logic k_inc;
        logic wr_other;     // order[j] = other, j--
        logic wr_key;       // order[j] = key, i++
        logic drn_tbl;      // read table entry of order[rank]
        logic drn_byte;     // read store at start + pos
        logic drn_res;      // form drain result and advance
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic i_lt_cnt;
        logic j_zero;
        logic cmp_end;
        logic len_before;
        logic byte_ne;
        logic byte_before;
        logic out_free;
        logic drain_last;
        logic cnt_zero;
    } t_stat;

endpackage

// ----- rtl/bss_dpath.sv -----
module bss_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bss_pkg::t_in_item i_in_data,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  bss_pkg::t_cmd    i_cmd,
    input  logic             i_out_ready,
    output bss_pkg::t_stat   o_stat,
    output logic             o_out_valid,
    output bss_pkg::t_out_item o_out_data
);
    import bss_pkg::*;

    // Memories
    logic [7:0]          r_store [MAX_BYTES];
    logic [7:0]          r_store_qa, r_store_qb;
    logic [2*BCNT_W-1:0] r_tbl [MAX_STRINGS];
    logic [2*BCNT_W-1:0] r_tbl_q;
    logic [SIDX_W-1:0]   r_ord [MAX_STRINGS];
    logic [SIDX_W-1:0]   r_ord_q;

    // Control registers
    logic [BCNT_W-1:0] r_byte_count, r_open_start, r_pos, r_offset;
    logic [SCNT_W-1:0] r_str_count, r_i, r_rank;
    logic              r_ovf, r_desc, r_out_valid;

    // Working registers of the sort
    logic [SIDX_W-1:0] r_j, r_key, r_oth;
    logic [BCNT_W-1:0] r_key_start, r_key_len, r_oth_start, r_oth_len, r_k;
    t_out_item         r_out;

    // Load decode
    logic              byte_ok, close, str_ok, ovf_set;
    logic [BCNT_W-1:0] n_byte_count;

    assign byte_ok = i_in_data.in_byte_present && (r_byte_count < BCNT_W'(MAX_BYTES));
    assign close   = i_in_data.in_string_end || i_in_data.in_set_end;
    assign str_ok  = close && (r_str_count < SCNT_W'(MAX_STRINGS));
    assign ovf_set = (i_in_data.in_byte_present && !byte_ok) || (close && !str_ok);
    assign n_byte_count = byte_ok ? r_byte_count + BCNT_W'(1) : r_byte_count;

    // Table entry fields
    logic [BCNT_W-1:0] tbl_start, tbl_len;
    assign tbl_start = r_tbl_q[2*BCNT_W-1:BCNT_W];
    assign tbl_len   = r_tbl_q[BCNT_W-1:0];

    // Store read addresses
    logic [BCNT_W-1:0] addr_a, addr_b;
    assign addr_a = i_cmd.cmp_rd ? r_key_start + r_k : tbl_start + r_pos;
    assign addr_b = r_oth_start + r_k;

    // Byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && byte_ok) begin
            r_store[r_byte_count[BIDX_W-1:0]] <= i_in_data.in_byte;
        end
        if (i_cmd.cmp_rd || i_cmd.drn_byte) begin
            r_store_qa <= r_store[addr_a[BIDX_W-1:0]];
        end
        if (i_cmd.cmp_rd) begin
            r_store_qb <= r_store[addr_b[BIDX_W-1:0]];
        end
    end

    // String table: start and length
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && str_ok) begin
            r_tbl[r_str_count[SIDX_W-1:0]] <= {r_open_start, n_byte_count - r_open_start};
        end
        if (i_cmd.key_cap || i_cmd.oth_cap || i_cmd.drn_tbl) begin
            r_tbl_q <= r_tbl[r_ord_q];
        end
    end

    // Order table write and read port select
    logic              ord_we, ord_re;
    logic [SIDX_W-1:0] ord_wa, ord_wd, ord_ra;

    always_comb begin
        ord_we = 1'b0;
        ord_wa = r_j;
        ord_wd = r_key;
        if (i_cmd.load && str_ok) begin
            ord_we = 1'b1;
            ord_wa = r_str_count[SIDX_W-1:0];
            ord_wd = r_str_count[SIDX_W-1:0];
        end else if (i_cmd.wr_other) begin
            ord_we = 1'b1;
            ord_wd = r_oth;
        end else if (i_cmd.wr_key) begin
            ord_we = 1'b1;
        end
        ord_re = i_cmd.ord_rd_i || i_cmd.ord_rd_jm1 || i_cmd.ord_rd_rank;
        if (i_cmd.ord_rd_i) begin
            ord_ra = r_i[SIDX_W-1:0];
        end else if (i_cmd.ord_rd_jm1) begin
            ord_ra = r_j - SIDX_W'(1);
        end else begin
            ord_ra = r_rank[SIDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_ord[ord_wa] <= ord_wd;
        end
        if (ord_re) begin
            r_ord_q <= r_ord[ord_ra];
        end
    end

    // Drain result decode
    logic              d_empty, d_end, d_last;
    logic [BCNT_W-1:0] n_pos;
    logic [SCNT_W-1:0] n_rank;

    assign d_empty = (tbl_len == '0);
    assign n_pos   = r_pos + BCNT_W'(1);
    assign d_end   = d_empty || (n_pos >= tbl_len);
    assign n_rank  = r_rank + SCNT_W'(1);
    assign d_last  = d_end && (n_rank >= r_str_count);

    // Set counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_open_start <= '0;
            r_str_count  <= '0;
            r_pos        <= '0;
            r_offset     <= '0;
            r_rank       <= '0;
            r_i          <= '0;
            r_ovf        <= 1'b0;
            r_desc       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_desc <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_byte_count <= n_byte_count;
                if (str_ok) begin
                    r_str_count <= r_str_count + SCNT_W'(1);
                end
                if (close) begin
                    r_open_start <= n_byte_count;
                end
                if (ovf_set) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.i_init) begin
                r_i <= SCNT_W'(1);
            end else if (i_cmd.wr_key) begin
                r_i <= r_i + SCNT_W'(1);
            end
            if (i_cmd.drn_res) begin
                if (d_last) begin
                    r_byte_count <= '0;
                    r_open_start <= '0;
                    r_str_count  <= '0;
                    r_pos        <= '0;
                    r_offset     <= '0;
                    r_rank       <= '0;
                    r_ovf        <= 1'b0;
                end else begin
                    if (!d_empty) begin
                        r_offset <= r_offset + BCNT_W'(1);
                    end
                    if (d_end) begin
                        r_pos  <= '0;
                        r_rank <= n_rank;
                    end else begin
                        r_pos <= n_pos;
                    end
                end
            end
        end
    end

    // Sort working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_cap) begin
            r_key <= r_ord_q;
            r_j   <= r_i[SIDX_W-1:0];
        end else if (i_cmd.wr_other) begin
            r_j <= r_j - SIDX_W'(1);
        end
        if (i_cmd.key_len_cap) begin
            r_key_start <= tbl_start;
            r_key_len   <= tbl_len;
        end
        if (i_cmd.oth_cap) begin
            r_oth <= r_ord_q;
        end
        if (i_cmd.oth_len_cap) begin
            r_oth_start <= tbl_start;
            r_oth_len   <= tbl_len;
            r_k         <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + BCNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.err_out || i_cmd.drn_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_out) begin
            r_out <= '{out_byte: 8'd0, out_byte_present: 1'b0, out_string_end: 1'b0,
                       offset_end: '0, last: 1'b0, status: ST_EMPTY};
        end else if (i_cmd.drn_res) begin
            r_out.out_byte         <= d_empty ? 8'd0 : r_store_qa;
            r_out.out_byte_present <= !d_empty;
            r_out.out_string_end   <= d_end;
            r_out.offset_end       <= OFS_W'(d_empty ? r_offset : r_offset + BCNT_W'(1));
            r_out.last             <= d_last;
            r_out.status           <= r_ovf ? ST_OVERFLOW : ST_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status to controller
    logic [BCNT_W-1:0] min_len;
    assign min_len = (r_key_len < r_oth_len) ? r_key_len : r_oth_len;

    always_comb begin
        o_stat.i_lt_cnt    = (r_i < r_str_count);
        o_stat.j_zero      = (r_j == '0);
        o_stat.cmp_end     = (r_k == min_len);
        o_stat.len_before  = r_desc ? (r_key_len > r_oth_len) : (r_key_len < r_oth_len);
        o_stat.byte_ne     = (r_store_qa != r_store_qb);
        o_stat.byte_before = r_desc ? (r_store_qa > r_store_qb) : (r_store_qa < r_store_qb);
        o_stat.out_free    = !r_out_valid || i_out_ready;
        o_stat.drain_last  = d_last;
        o_stat.cnt_zero    = (r_str_count == '0);
    end

endmodule

// ----- rtl/bss_ctrl.sv -----
module bss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_operation,
    input  logic           i_set_end,
    input  bss_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output bss_pkg::t_cmd  o_cmd
);
    import bss_pkg::*;

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_DRAIN = 14'b00000000000010,
        S_SORTI = 14'b00000000000100,
        S_KEY1  = 14'b00000000001000,
        S_KEY2  = 14'b00000000010000,
        S_SORTJ = 14'b00000000100000,
        S_OTH1  = 14'b00000001000000,
        S_OTH2  = 14'b00000010000000,
        S_CMP   = 14'b00000100000000,
        S_CMPW  = 14'b00001000000000,
        S_DORD  = 14'b00010000000000,
        S_DTBL  = 14'b00100000000000,
        S_DBYTE = 14'b01000000000000,
        S_DRES  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = ((r_state == S_LOAD) || (r_state == S_DRAIN)) && i_stat.out_free;
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (i_operation == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_set_end) begin
                            o_cmd.i_init = 1'b1;
                            n_state      = S_SORTI;
                        end
                    end else begin
                        o_cmd.err_out = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                // load transactions are dropped here
                if (accept && (i_operation == OP_DRAIN)) begin
                    n_state = S_DORD;
                end
            end
            S_SORTI: begin
                if (i_stat.i_lt_cnt) begin
                    o_cmd.ord_rd_i = 1'b1;
                    n_state        = S_KEY1;
                end else begin
                    n_state = i_stat.cnt_zero ? S_LOAD : S_DRAIN;
                end
            end
            S_KEY1: begin
                o_cmd.key_cap = 1'b1;
                n_state       = S_KEY2;
            end
            S_KEY2: begin
                o_cmd.key_len_cap = 1'b1;
                n_state           = S_SORTJ;
            end
            S_SORTJ: begin
                if (i_stat.j_zero) begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_SORTI;
                end else begin
                    o_cmd.ord_rd_jm1 = 1'b1;
                    n_state          = S_OTH1;
                end
            end
            S_OTH1: begin
                o_cmd.oth_cap = 1'b1;
                n_state       = S_OTH2;
            end
            S_OTH2: begin
                o_cmd.oth_len_cap = 1'b1;
                n_state           = S_CMP;
            end
            S_CMP: begin
                // common prefix exhausted: lengths decide
                if (i_stat.cmp_end) begin
                    if (i_stat.len_before) begin
                        o_cmd.wr_other = 1'b1;
                        n_state        = S_SORTJ;
                    end else begin
                        o_cmd.wr_key = 1'b1;
                        n_state      = S_SORTI;
                    end
                end else begin
                    o_cmd.cmp_rd = 1'b1;
                    n_state      = S_CMPW;
                end
            end
            S_CMPW: begin
                if (i_stat.byte_ne) begin
                    if (i_stat.byte_before) begin
                        o_cmd.wr_other = 1'b1;
                        n_state        = S_SORTJ;
                    end else begin
                        o_cmd.wr_key = 1'b1;
                        n_state      = S_SORTI;
                    end
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_DORD: begin
                o_cmd.ord_rd_rank = 1'b1;
                n_state           = S_DTBL;
            end
            S_DTBL: begin
                o_cmd.drn_tbl = 1'b1;
                n_state       = S_DBYTE;
            end
            S_DBYTE: begin
                o_cmd.drn_byte = 1'b1;
                n_state        = S_DRES;
            end
            S_DRES: begin
                o_cmd.drn_res = 1'b1;
                n_state       = i_stat.drain_last ? S_LOAD : S_DRAIN;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/byte_string_sorter_unit.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_data (t_out_item)
// config    in         i_cfg_wr_en                i_cfg_wr_data (descending)
//
// A drain transaction runs three chained reads (order table, string table,
// byte store) and then forms the result.
// Closing the set runs an insertion sort over the order table, input held off meanwhile.
// Reset is synchronous and active low and clears counts and flags; the stores need none.
// A result waiting in the output register blocks new input only until it is taken.
module byte_string_sorter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bss_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bss_pkg::t_out_item o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);
    import bss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    bss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .i_set_end   (i_in_data.in_set_end),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // Stores, counters and output register
    bss_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_out_ready   (i_out_ready),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

`ifndef SYNTH
    // a result is only written into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.err_out || cmd.drn_res) |-> stat.out_free)
        else $error("result written over a pending transaction");

    // closing the set holds off input while the sort runs
    a_sort_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && i_in_data.in_set_end) |=> !o_in_ready)
        else $error("input accepted during sort");

    // a load transaction never creates a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.operation == OP_LOAD) && !o_out_valid)
        |=> !o_out_valid)
        else $error("result after load transaction");
`endif

endmodule
